// ===== hdl/sha256_hash_engine_assert.svh =====
// Assertion helpers shared by the engine RTL.
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sha_pkg.sv =====
package sha_pkg;

	typedef logic [31:0] word_t;
	typedef word_t chain_t [8];

	// Sequencer states
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PAD   = 6'b000010,
		S_WLOAD = 6'b000100,
		S_ROUND = 6'b001000,
		S_FOLD  = 6'b010000,
		S_OUT   = 6'b100000
	} seq_state_t;

	// Controls from the sequencer to the message schedule
	typedef struct packed {
		logic       push;
		logic       step;
		logic [5:0] t;
	} sched_ctrl_t;

	// Controls from the sequencer to the round unit
	typedef struct packed {
		logic init;
		logic step;
		logic fold;
		logic restart;
	} round_ctrl_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	localparam chain_t INIT_H = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Rotate a word right by a constant amount
	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== hdl/sha_if.sv =====
// Byte request channel into the engine
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

// Digest word channel out of the engine
interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha_sched.sv =====
module sha_sched (
	input  logic                clk,
	input  sha_pkg::sched_ctrl_t ctrl,
	input  sha_pkg::word_t      word_in,
	output sha_pkg::word_t      wk
);
	import sha_pkg::*;

	word_t win_q [16];
	word_t wk_q;
	word_t w_new;
	word_t s0;
	word_t s1;

	// Pass loaded words while t < 16, then expand from the window taps
	always_comb begin
		s0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
		s1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
		if (ctrl.t < 6'd16) begin
			w_new = win_q[0];
		end else begin
			w_new = win_q[0] + s0 + win_q[9] + s1;
		end
	end

	// Shift the window on a loaded word or a schedule step
	always_ff @(posedge clk) begin
		if (ctrl.push || ctrl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= ctrl.push ? word_in : w_new;
		end
		if (ctrl.step) begin
			wk_q <= w_new + ROUND_K[ctrl.t];
		end
	end

	assign wk = wk_q;

endmodule

// ===== hdl/sha_round.sv =====
module sha_round (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_pkg::round_ctrl_t ctrl,
	input  sha_pkg::word_t      wk,
	output sha_pkg::chain_t     chain
);
	import sha_pkg::*;

	chain_t chain_q;
	chain_t work_q;
	word_t  t1;
	word_t  t2;
	word_t  ch;
	word_t  maj;
	word_t  sig_a;
	word_t  sig_e;

	// Compression round on the working words a..h
	always_comb begin
		sig_a = rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22);
		sig_e = rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25);
		ch    = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj   = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1    = work_q[7] + sig_e + ch + wk;
		t2    = sig_a + maj;
	end

	// Load, advance the working words
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			work_q <= chain_q;
		end else if (ctrl.step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	// Fold the block result into the chaining state, restart per message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= INIT_H;
		end else if (ctrl.restart) begin
			chain_q <= INIT_H;
		end else if (ctrl.fold) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + work_q[i];
			end
		end
	end

	assign chain = chain_q;

endmodule

// ===== hdl/sha256_hash_engine.sv =====
// SHA-256 engine, one message byte per request.
// req_in carries data_byte with byte_present, and end_of_message to close
// the message; a request may hold a byte, an end mark, both or neither.
// dig_out gives eight digest words, word_index 0 first, last_word on 7.
// A byte that does not fill the 64-byte block is taken with ready kept high.
// The byte that fills a block starts a compression (schedule preload,
// 64 rounds on the shared round unit, chaining fold); ready stays low.
// A closing request pads one byte per cycle up to the end of the block,
// and on through a second block when one is needed; each padded block is
// then compressed, and after the last fold the engine enters the output
// state and loads the first digest word once the output register is free.
// Requests wait out each compression, so the round unit sets the rate.
// Reset clears the chaining state to the initial hash, the bit count and
// the block fill; the engine comes out of reset ready.
// A stalled receiver holds the output register; the engine waits for each
// digest word to drain, and accepts the next request once the eighth word
// sits in the output register.
module sha256_hash_engine (
	input logic      clk,
	input logic      arst_n,
	sha_in_if.sink   req_in,
	sha_out_if.source dig_out
);
	import sha_pkg::*;

	seq_state_t  state_q;
	logic [5:0]  fill_q;
	logic [23:0] acc_q;
	logic [63:0] count_q;
	logic [63:0] len_q;
	logic        pad_q;
	logic        first_q;
	logic        final_q;
	logic        last_blk_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic        out_valid_q;
	word_t       out_word_q;
	logic [2:0]  out_index_q;
	logic        out_last_q;

	logic        accept;
	logic        byte_push;
	logic [7:0]  byte_val;
	logic [7:0]  pad_byte;
	logic        final_now;
	logic        blk_full;
	logic        out_load;
	sched_ctrl_t sctrl;
	round_ctrl_t rctrl;
	word_t       wk;
	chain_t      chain;

	sha_sched u_sched (
		.clk     (clk),
		.ctrl    (sctrl),
		.word_in ({acc_q, byte_val}),
		.wk      (wk)
	);

	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rctrl),
		.wk     (wk),
		.chain  (chain)
	);

	// Pick the byte entering the block; derive accept, push and output load
	always_comb begin
		final_now = first_q ? (fill_q < LEN_START) : final_q;
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (final_q && fill_q >= LEN_START) begin
			pad_byte = len_q[63:56];
		end else begin
			pad_byte = 8'h00;
		end
		accept    = req_in.valid && (state_q == S_IDLE);
		byte_push = (accept && req_in.byte_present) || (state_q == S_PAD);
		byte_val  = (state_q == S_PAD) ? pad_byte : req_in.data_byte;
		blk_full  = byte_push && (fill_q == 6'd63);
		out_load  = (state_q == S_OUT) && (!out_valid_q || dig_out.ready);
	end

	// Drive schedule and round unit controls
	always_comb begin
		sctrl.push    = byte_push && (fill_q[1:0] == 2'b11);
		sctrl.step    = (state_q == S_WLOAD) || ((state_q == S_ROUND) && (round_q != 6'd63));
		sctrl.t       = (state_q == S_WLOAD) ? 6'd0 : round_q + 6'd1;
		rctrl.init    = (state_q == S_WLOAD);
		rctrl.step    = (state_q == S_ROUND);
		rctrl.fold    = (state_q == S_FOLD);
		rctrl.restart = out_load && (idx_q == 3'd7);
	end

	// Sequence requests, padding, compression and digest output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			count_q    <= '0;
			pad_q      <= 1'b0;
			first_q    <= 1'b0;
			final_q    <= 1'b0;
			last_blk_q <= 1'b0;
			round_q    <= '0;
			idx_q      <= '0;
		end else begin
			if (byte_push) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_in.byte_present) begin
							count_q <= count_q + 64'd8;
						end
						if (req_in.end_of_message) begin
							pad_q   <= 1'b1;
							first_q <= 1'b1;
						end
						if (blk_full) begin
							state_q    <= S_WLOAD;
							last_blk_q <= 1'b0;
						end else if (req_in.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					if (first_q) begin
						final_q <= final_now;
					end
					if (blk_full) begin
						state_q    <= S_WLOAD;
						last_blk_q <= final_now;
					end
				end
				S_WLOAD: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (!pad_q) begin
						state_q <= S_IDLE;
					end else if (last_blk_q) begin
						state_q <= S_OUT;
						idx_q   <= '0;
					end else begin
						state_q <= S_PAD;
						final_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_load) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= S_IDLE;
							pad_q   <= 1'b0;
							count_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Gather bytes into words, hold and shift out the bit length
	always_ff @(posedge clk) begin
		if (byte_push) begin
			acc_q <= {acc_q[15:0], byte_val};
		end
		if (accept && req_in.end_of_message) begin
			len_q <= count_q + (req_in.byte_present ? 64'd8 : 64'd0);
		end else if (state_q == S_PAD && !first_q && final_q && fill_q >= LEN_START) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Hold digest words until the receiver takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dig_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q  <= chain[idx_q];
			out_index_q <= idx_q;
			out_last_q  <= (idx_q == 3'd7);
		end
	end

	assign req_in.ready        = (state_q == S_IDLE);
	assign dig_out.valid       = out_valid_q;
	assign dig_out.digest_word = out_word_q;
	assign dig_out.word_index  = out_index_q;
	assign dig_out.last_word   = out_last_q;

	`include "sha256_hash_engine_assert.svh"

	`SHA_ASSERT_NEXT(a_close_starts_pad, accept && req_in.end_of_message, state_q != S_IDLE, "closing request did not start padding")
	`SHA_ASSERT_NOW(a_out_block_aligned, state_q == S_OUT, fill_q == 6'd0, "digest output with partial block")
	`SHA_ASSERT_NOW(a_round_idle_zero, state_q != S_ROUND, round_q == 6'd0, "round counter off outside rounds")
	`SHA_ASSERT_NOW(a_last_is_seven, out_valid_q && out_last_q, out_index_q == 3'd7, "last digest word not at index seven")

endmodule
